### rtl/dttd_pkg.sv
package dttd_pkg;

   localparam int EXPONENT_LIMIT_DEFAULT = 9999;
   localparam int COUNT_LIMIT_DEFAULT    = 65535;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_E = 8'h65;

   localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] DBL_ZERO = 64'h0;

   // Significand of the binary64 constant 0.1; 0.1 equals it times 2**-56.
   localparam logic [52:0] TENTH_SIG = 53'h1999999999999A;
   localparam logic [26:0] TENTH_LO  = TENTH_SIG[26:0];
   localparam logic [25:0] TENTH_HI  = TENTH_SIG[52:27];

   typedef enum logic [2:0] {
      OP_MUL10 = 3'b001,
      OP_MUL01 = 3'b010,
      OP_ADD   = 3'b100
   } fpu_op_type;

   typedef struct packed {
      logic        start;
      fpu_op_type  op;
      logic [3:0]  digit;
      logic [63:0] operand;
   } fpu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] bits;
   } fpu_rsp_type;

endpackage

### rtl/dttd_fpu.sv
module dttd_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  dttd_pkg::fpu_cmd_type cmd,
   output dttd_pkg::fpu_rsp_type rsp
);

   typedef enum logic [5:0] {
      F_IDLE  = 6'b000001,
      F_MUL   = 6'b000010,
      F_NORM  = 6'b000100,
      F_SHIFT = 6'b001000,
      F_PACK  = 6'b010000,
      F_DONE  = 6'b100000
   } fstate_type;

   typedef enum logic [2:0] {
      LB_ADD = 3'b001,
      LB_M10 = 3'b010,
      LB_M01 = 3'b100
   } lead_base_type;

   fstate_type          state_ff, state_in;
   lead_base_type       lb_ff, lb_in;
   logic [52:0]         sig_ff, sig_in;
   logic [111:0]        p_ff, p_in;
   logic signed [13:0]  q_ff, q_in;
   logic                sub_ff, sub_in;
   logic [1:0]          step_ff, step_in;
   logic [6:0]          r_ff, r_in;
   logic [12:0]         e_ff, e_in;
   logic [53:0]         kept_ff, kept_in;
   logic                rbit_ff, rbit_in;
   logic                sticky_ff, sticky_in;
   logic [63:0]         res_ff, res_in;

   // Operand unpacking.
   logic [10:0]         x_ex;
   logic                x_inf, x_zero;
   logic [52:0]         x_sig;
   logic signed [13:0]  x_q;
   logic signed [13:0]  x_nq;

   // Partial product.
   logic [26:0]         a_part, k_part;
   logic [53:0]         pp;
   logic [6:0]          pp_shift;

   // Normalization.
   logic [7:0]          win;
   logic [6:0]          lead_base, lead_off, lead;
   logic signed [13:0]  e_full, r_sub;

   // Rounding.
   logic [112:0]        y;
   logic [111:0]        p_shr;
   logic [112:0]        y_shr;
   logic                inc;
   logic [53:0]         sig_rnd;
   logic [63:0]         packed_sum;

   assign x_ex   = cmd.operand[62:52];
   assign x_inf  = (x_ex == 11'h7FF);
   assign x_zero = (cmd.operand[62:0] == 63'd0);
   assign x_sig  = {x_ex != 11'd0, cmd.operand[51:0]};
   assign x_q    = $signed({3'b000, (x_ex == 11'd0) ? 11'd1 : x_ex}) - 14'sd1075;
   assign x_nq   = -x_q;

   assign a_part   = step_ff[1] ? {1'b0, sig_ff[52:27]} : sig_ff[26:0];
   assign k_part   = step_ff[0] ? {1'b0, dttd_pkg::TENTH_HI} : dttd_pkg::TENTH_LO;
   assign pp       = a_part * k_part;
   assign pp_shift = (step_ff == 2'd0) ? 7'd0 : ((step_ff == 2'd3) ? 7'd54 : 7'd27);

   always_comb begin
      win       = p_ff[59:52];
      lead_base = 7'd52;
      case (lb_ff)
         LB_M10: begin
            win       = p_ff[62:55];
            lead_base = 7'd55;
         end
         LB_M01: begin
            win       = p_ff[111:104];
            lead_base = 7'd104;
         end
         default: begin
            win       = p_ff[59:52];
            lead_base = 7'd52;
         end
      endcase
      lead_off = 7'd0;
      for (int i = 0; i < 8; i++) begin
         if (win[i]) lead_off = 7'(i);
      end
   end

   assign lead   = lead_base + lead_off;
   assign e_full = q_ff + $signed({7'b0, lead}) + 14'sd1023;
   assign r_sub  = -14'sd1074 - q_ff;

   assign y       = {p_ff, 1'b0};
   assign p_shr   = p_ff >> r_ff;
   assign y_shr   = y >> r_ff;
   assign inc     = rbit_ff & (sticky_ff | kept_ff[0]);
   assign sig_rnd = kept_ff + {53'd0, inc};
   assign packed_sum = ({51'd0, e_ff - 13'd1} << 52) + {10'd0, sig_rnd};

   always_comb begin
      state_in  = state_ff;
      lb_in     = lb_ff;
      sig_in    = sig_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      sub_in    = sub_ff;
      step_in   = step_ff;
      r_in      = r_ff;
      e_in      = e_ff;
      kept_in   = kept_ff;
      rbit_in   = rbit_ff;
      sticky_in = sticky_ff;
      res_in    = res_ff;
      unique case (state_ff)
         // A new command may arrive in the same cycle that the previous result is shown.
         F_IDLE, F_DONE: begin
            state_in = F_IDLE;
            if (cmd.start) begin
               sub_in   = 1'b0;
               step_in  = 2'd0;
               sig_in   = x_sig;
               state_in = F_NORM;
               case (cmd.op)
                  dttd_pkg::OP_MUL10: begin
                     p_in  = ({59'd0, x_sig} << 3) + ({59'd0, x_sig} << 1);
                     q_in  = x_q;
                     lb_in = LB_M10;
                  end
                  dttd_pkg::OP_MUL01: begin
                     p_in     = 112'd0;
                     q_in     = x_q - 14'sd56;
                     lb_in    = LB_M01;
                     sub_in   = (x_ex == 11'd0);
                     state_in = F_MUL;
                  end
                  default: begin
                     lb_in = LB_ADD;
                     if (x_zero) begin
                        p_in = {108'd0, cmd.digit} << 52;
                        q_in = -14'sd52;
                     end else if (x_q >= 14'sd5) begin
                        // The digit is below half an ulp here, so the sum is the operand.
                        res_in   = cmd.operand;
                        state_in = F_DONE;
                     end else if (x_q >= 14'sd0) begin
                        p_in = ({59'd0, x_sig} << x_q[2:0]) + {108'd0, cmd.digit};
                        q_in = 14'sd0;
                     end else begin
                        p_in = {59'd0, x_sig} +
                               ({108'd0, cmd.digit} << ((x_nq > 14'sd63) ? 6'd63 : x_nq[5:0]));
                        q_in = x_q;
                     end
                  end
               endcase
               if (x_inf) begin
                  res_in   = dttd_pkg::DBL_INF;
                  state_in = F_DONE;
               end else if (x_zero && cmd.op != dttd_pkg::OP_ADD) begin
                  res_in   = dttd_pkg::DBL_ZERO;
                  state_in = F_DONE;
               end
            end
         end
         F_MUL: begin
            p_in    = p_ff + ({58'd0, pp} << pp_shift);
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = F_NORM;
         end
         F_NORM: begin
            if (p_ff == 112'd0) begin
               res_in   = dttd_pkg::DBL_ZERO;
               state_in = F_DONE;
            end else begin
               state_in = F_SHIFT;
               if (sub_ff) begin
                  r_in = 7'd56;
                  e_in = 13'd1;
               end else if (e_full >= 14'sd1) begin
                  r_in = lead - 7'd52;
                  e_in = e_full[12:0];
               end else begin
                  r_in = (r_sub > 14'sd127) ? 7'd127 : r_sub[6:0];
                  e_in = 13'd1;
               end
            end
         end
         F_SHIFT: begin
            kept_in   = p_shr[53:0];
            rbit_in   = y_shr[0];
            sticky_in = |(y & ~({113{1'b1}} << r_ff));
            state_in  = F_PACK;
         end
         F_PACK: begin
            if (e_ff > 13'd2046 || packed_sum[62:52] == 11'h7FF) begin
               res_in = dttd_pkg::DBL_INF;
            end else begin
               res_in = packed_sum;
            end
            state_in = F_DONE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lb_ff     <= lb_in;
      sig_ff    <= sig_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      sub_ff    <= sub_in;
      step_ff   <= step_in;
      r_ff      <= r_in;
      e_ff      <= e_in;
      kept_ff   <= kept_in;
      rbit_ff   <= rbit_in;
      sticky_ff <= sticky_in;
      res_ff    <= res_in;
   end

   assign rsp.done = (state_ff == F_DONE);
   assign rsp.bits = res_ff;

endmodule

### rtl/decimal_text_to_double_top.sv
// Decimal text to binary64 converter. Characters enter one per transaction; a transaction
// with req_begins_text set starts a new text. Sign, integer digits, fraction and exponent
// are parsed, and the first character that does not fit ends the text and yields one
// result transaction: the signed value and the count of characters consumed. Every
// arithmetic step runs on one shared floating-point unit. A sign, point or exponent
// character needs no arithmetic step, a mantissa digit is a times-ten step then a digit
// add, and the terminating character runs one times-ten or times-0.1 scaling step per
// unit of net exponent, ending early once the value reaches zero or infinity, then waits
// for any earlier result still held by rsp_stall. A new character is taken while an
// earlier result still waits on rsp_stall.
module decimal_text_to_double_top #(
   parameter int EXPONENT_LIMIT = dttd_pkg::EXPONENT_LIMIT_DEFAULT,
   parameter int COUNT_LIMIT    = dttd_pkg::COUNT_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_begins_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value_bits,
   output logic [15:0] rsp_consumed_count
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_ADD   = 6'b000100,
      S_SCALE = 6'b001000,
      S_SWAIT = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_FIRST = 6'b000010,
      PH_INT   = 6'b000100,
      PH_FRAC  = 6'b001000,
      PH_ESIGN = 6'b010000,
      PH_EDIG  = 6'b100000
   } phase_type;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [63:0]        mant_ff, mant_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] shift_ff, shift_in;
   logic               eneg_ff, eneg_in;
   logic [13:0]        exp_ff, exp_in;
   logic [15:0]        taken_ff, taken_in;
   logic [3:0]         digit_ff, digit_in;
   logic               up_ff, up_in;
   logic [16:0]        cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_bits_ff, rsp_bits_in;
   logic [15:0]        rsp_count_ff, rsp_count_in;

   dttd_pkg::fpu_cmd_type fpu_cmd;
   dttd_pkg::fpu_rsp_type fpu_rsp;

   logic               accept, start;
   logic [63:0]        b_mant;
   logic               b_neg, b_eneg;
   logic signed [15:0] b_shift;
   logic [13:0]        b_exp;
   logic [15:0]        b_taken, taken_inc;
   logic               is_digit, is_sign, is_emark;
   logic [3:0]         dig;
   logic [17:0]        exp_next;
   logic signed [16:0] net;
   phase_type          ph;
   logic               handled, take, fold, finish;
   logic               out_free, scale_end;

   assign accept  = req_valid && (state_ff == S_IDLE);
   assign start   = req_begins_text;
   assign b_mant  = start ? 64'd0 : mant_ff;
   assign b_neg   = start ? 1'b0 : neg_ff;
   assign b_shift = start ? 16'sd0 : shift_ff;
   assign b_eneg  = start ? 1'b0 : eneg_ff;
   assign b_exp   = start ? 14'd0 : exp_ff;
   assign b_taken = start ? 16'd0 : taken_ff;
   assign taken_inc = (b_taken < 16'(COUNT_LIMIT)) ? b_taken + 16'd1 : b_taken;

   assign is_digit = (req_character >= dttd_pkg::CH_ZERO) &&
                     (req_character <= dttd_pkg::CH_NINE);
   assign is_sign  = (req_character == dttd_pkg::CH_PLUS) ||
                     (req_character == dttd_pkg::CH_MINUS);
   assign is_emark = (req_character == dttd_pkg::CH_UPPER_E) ||
                     (req_character == dttd_pkg::CH_LOWER_E);
   assign dig      = 4'(req_character - dttd_pkg::CH_ZERO);
   assign exp_next = ({4'd0, b_exp} << 3) + ({4'd0, b_exp} << 1) + {14'd0, dig};
   assign net      = b_eneg ? (17'(b_shift) - $signed({3'b000, b_exp}))
                            : (17'(b_shift) + $signed({3'b000, b_exp}));

   // Character decode: settles which action this character causes.
   always_comb begin
      ph       = start ? PH_FIRST : phase_ff;
      handled  = 1'b0;
      take     = 1'b0;
      fold     = 1'b0;
      finish   = 1'b0;
      phase_in = ph;
      neg_in   = b_neg;
      eneg_in  = b_eneg;
      exp_in   = b_exp;
      shift_in = b_shift;
      if (!start && phase_ff == PH_IDLE) begin
         handled  = 1'b1;
         phase_in = PH_IDLE;
      end
      if (!handled && ph == PH_FIRST) begin
         if (is_sign) begin
            neg_in   = (req_character == dttd_pkg::CH_MINUS);
            take     = 1'b1;
            phase_in = PH_INT;
            handled  = 1'b1;
         end else begin
            ph = PH_INT;
         end
      end
      if (!handled && (ph == PH_INT || ph == PH_FRAC)) begin
         handled = 1'b1;
         if (is_digit) begin
            fold     = 1'b1;
            take     = 1'b1;
            phase_in = ph;
            if (ph == PH_FRAC && b_shift != 16'sh8000) shift_in = b_shift - 16'sd1;
         end else if (ph == PH_INT && req_character == dttd_pkg::CH_DOT) begin
            take     = 1'b1;
            phase_in = PH_FRAC;
         end else if (is_emark) begin
            take     = 1'b1;
            phase_in = PH_ESIGN;
         end else begin
            finish   = 1'b1;
            phase_in = PH_IDLE;
         end
      end
      if (!handled && ph == PH_ESIGN) begin
         if (is_sign) begin
            eneg_in  = (req_character == dttd_pkg::CH_MINUS);
            take     = 1'b1;
            phase_in = PH_EDIG;
            handled  = 1'b1;
         end else begin
            ph = PH_EDIG;
         end
      end
      if (!handled && ph == PH_EDIG) begin
         handled = 1'b1;
         if (is_digit) begin
            exp_in   = (exp_next > 18'(EXPONENT_LIMIT)) ? 14'(EXPONENT_LIMIT)
                                                        : exp_next[13:0];
            take     = 1'b1;
            phase_in = PH_EDIG;
         end else begin
            finish   = 1'b1;
            phase_in = PH_IDLE;
         end
      end
      if (!handled) phase_in = PH_IDLE;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scale_end = (cnt_ff == 17'd0) || (mant_ff[62:0] == 63'd0) ||
                      (mant_ff[62:52] == 11'h7FF);

   always_comb begin
      state_in     = state_ff;
      mant_in      = mant_ff;
      taken_in     = taken_ff;
      digit_in     = digit_ff;
      up_in        = up_ff;
      cnt_in       = cnt_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      fpu_cmd.start   = 1'b0;
      fpu_cmd.op      = dttd_pkg::OP_MUL10;
      fpu_cmd.digit   = digit_ff;
      fpu_cmd.operand = mant_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mant_in  = b_mant;
               taken_in = take ? taken_inc : b_taken;
               digit_in = dig;
               if (fold) begin
                  fpu_cmd.start   = 1'b1;
                  fpu_cmd.operand = b_mant;
                  state_in        = S_MUL;
               end else if (finish) begin
                  up_in    = (net > 17'sd0);
                  cnt_in   = (net < 17'sd0) ? 17'(-net) : 17'(net);
                  state_in = S_SCALE;
               end
            end
         end
         S_MUL: begin
            if (fpu_rsp.done) begin
               fpu_cmd.start   = 1'b1;
               fpu_cmd.op      = dttd_pkg::OP_ADD;
               fpu_cmd.operand = fpu_rsp.bits;
               state_in        = S_ADD;
            end
         end
         S_ADD: begin
            if (fpu_rsp.done) begin
               mant_in  = fpu_rsp.bits;
               state_in = S_IDLE;
            end
         end
         S_SCALE: begin
            if (scale_end) begin
               state_in = S_OUT;
            end else begin
               fpu_cmd.start = 1'b1;
               fpu_cmd.op    = up_ff ? dttd_pkg::OP_MUL10 : dttd_pkg::OP_MUL01;
               state_in      = S_SWAIT;
            end
         end
         S_SWAIT: begin
            if (fpu_rsp.done) begin
               mant_in  = fpu_rsp.bits;
               cnt_in   = cnt_ff - 17'd1;
               state_in = S_SCALE;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_bits_in  = {neg_ff, mant_ff[62:0]};
               rsp_count_in = taken_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         mant_ff      <= 64'd0;
         neg_ff       <= 1'b0;
         shift_ff     <= 16'sd0;
         eneg_ff      <= 1'b0;
         exp_ff       <= 14'd0;
         taken_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mant_ff      <= mant_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            shift_ff <= shift_in;
            eneg_ff  <= eneg_in;
            exp_ff   <= exp_in;
         end
      end
      digit_ff     <= digit_in;
      up_ff        <= up_in;
      cnt_ff       <= cnt_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_count_ff <= rsp_count_in;
   end

   dttd_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .cmd   (fpu_cmd),
      .rsp   (fpu_rsp)
   );

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value_bits     = rsp_bits_ff;
   assign rsp_consumed_count = rsp_count_ff;

endmodule

### rtl/dttd_checker.sv
module dttd_checker #(
   parameter int COUNT_LIMIT = dttd_pkg::COUNT_LIMIT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_value_bits,
   input logic [15:0] rsp_consumed_count
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_bits) &&
                                 $stable(rsp_consumed_count))
      else $error("stalled result changed");

   // A new result appears only after the converter was busy with the terminator.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a terminating transaction");

   // The converter never produces a NaN.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_bits[62:52] == 11'h7FF |-> rsp_value_bits[51:0] == 52'd0)
      else $error("NaN result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_consumed_count <= 16'(COUNT_LIMIT))
      else $error("consumed count above limit");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind decimal_text_to_double_top dttd_checker #(.COUNT_LIMIT(COUNT_LIMIT)) u_checker (.*);

### test/decimal_text_to_double_top_test.sv
module decimal_text_to_double_top_test;

   typedef struct {
      logic [7:0] ch;
      logic       begins;
      bit         drain;
   } char_item_type;

   typedef struct {
      logic [63:0] bits;
      logic [15:0] count;
   } conversion_type;

   typedef enum int {P_IDLE, P_FIRST, P_INT, P_FRAC, P_ESIGN, P_EDIG} phase_type;

   localparam int EXP_MAX   = dttd_pkg::EXPONENT_LIMIT_DEFAULT;
   localparam int COUNT_MAX = dttd_pkg::COUNT_LIMIT_DEFAULT;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = 8'h00;
   logic        req_begins_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value_bits;
   logic [15:0] rsp_consumed_count;

   char_item_type  pending_chars[$];
   conversion_type expected_conversions[$];
   int             mismatch_count = 0;

   // Predictor state.
   phase_type phase = P_IDLE;
   real    mant = 0.0;
   bit     neg = 1'b0;
   int     shift = 0;
   bit     exp_neg = 1'b0;
   int     exp_val = 0;
   int     taken = 0;

   decimal_text_to_double_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_character(req_character), .req_begins_text(req_begins_text),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value_bits(rsp_value_bits), .rsp_consumed_count(rsp_consumed_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_digit(logic [7:0] c);
      return c >= dttd_pkg::CH_ZERO && c <= dttd_pkg::CH_NINE;
   endfunction

   function automatic void count_char();
      if (taken < COUNT_MAX) taken++;
   endfunction

   function automatic void end_conversion();
      int             net;
      real            v;
      conversion_type r;
      net = exp_neg ? shift - exp_val : shift + exp_val;
      v = mant;
      while (net > 0) begin
         v = v * 10.0;
         net--;
      end
      while (net < 0) begin
         v = v * 0.1;
         net++;
      end
      r.bits = $realtobits(v);
      if (neg) r.bits[63] = ~r.bits[63];
      r.count = taken[15:0];
      expected_conversions.push_back(r);
      phase = P_IDLE;
   endfunction

   // Advances the parser by one accepted character; queues a conversion when one ends.
   function automatic void parse_char(logic [7:0] c, logic begins);
      if (begins) begin
         mant = 0.0; neg = 0; shift = 0; exp_neg = 0; exp_val = 0; taken = 0;
         phase = P_FIRST;
      end else if (phase == P_IDLE) begin
         return;
      end
      if (phase == P_FIRST) begin
         phase = P_INT;
         if (c == dttd_pkg::CH_PLUS || c == dttd_pkg::CH_MINUS) begin
            neg = (c == dttd_pkg::CH_MINUS);
            count_char();
            return;
         end
      end
      if (phase == P_INT || phase == P_FRAC) begin
         if (is_digit(c)) begin
            mant = mant * 10.0;
            mant = mant + real'(int'(c - dttd_pkg::CH_ZERO));
            if (phase == P_FRAC && shift > -32768) shift--;
            count_char();
         end else if (phase == P_INT && c == dttd_pkg::CH_DOT) begin
            count_char();
            phase = P_FRAC;
         end else if (c == dttd_pkg::CH_UPPER_E || c == dttd_pkg::CH_LOWER_E) begin
            count_char();
            phase = P_ESIGN;
         end else begin
            end_conversion();
         end
         return;
      end
      if (phase == P_ESIGN) begin
         phase = P_EDIG;
         if (c == dttd_pkg::CH_PLUS || c == dttd_pkg::CH_MINUS) begin
            exp_neg = (c == dttd_pkg::CH_MINUS);
            count_char();
            return;
         end
      end
      if (phase == P_EDIG) begin
         if (is_digit(c)) begin
            exp_val = exp_val * 10 + int'(c - dttd_pkg::CH_ZERO);
            if (exp_val > EXP_MAX) exp_val = EXP_MAX;
            count_char();
         end else begin
            end_conversion();
         end
      end
   endfunction

   task automatic add_text(string s, logic [7:0] term, logic term_begins, bit drain);
      char_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.ch = s[i];
         it.begins = (i == 0);
         it.drain = drain && (i == 0);
         pending_chars.push_back(it);
      end
      it.ch = term;
      it.begins = term_begins;
      it.drain = 0;
      pending_chars.push_back(it);
   endtask

   function automatic string digit_run(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
      return s;
   endfunction

   // Number-like text with random content; a run of digits may be empty.
   function automatic string random_number();
      string s;
      int    k;
      s = "";
      k = $urandom_range(3);
      if (k == 1) s = "+";
      else if (k == 2) s = "-";
      s = {s, digit_run($urandom_range(1) ? $urandom_range(4) : $urandom_range(20))};
      if ($urandom_range(1)) s = {s, ".", digit_run($urandom_range(12))};
      if ($urandom_range(2) == 0) begin
         s = {s, $urandom_range(1) ? "e" : "E"};
         k = $urandom_range(2);
         if (k == 1) s = {s, "+"};
         else if (k == 2) s = {s, "-"};
         s = {s, digit_run($urandom_range(9) == 0 ? $urandom_range(5) : $urandom_range(2))};
      end
      return s;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_char(req_character, req_begins_text);
            void'(pending_chars.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].drain && expected_conversions.size() > 0)) begin
               req_valid <= 1'b1;
               req_character <= pending_chars[0].ch;
               req_begins_text <= pending_chars[0].begins;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(3) == 0 ? $urandom_range(200, 50)
                                                       : $urandom_range(12, 1);
                  gap_left <= $urandom_range(2) == 0 ? 0 : $urandom_range(15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes character every so often.
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(2);
         mode_left <= $urandom_range(300, 30);
         rsp_stall <= 1'b0;
      end else begin
         mode_left <= mode_left - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= $urandom_range(1);
            default: rsp_stall <= $urandom_range(7) != 0;
         endcase
      end
   end

   always @(posedge clock) begin
      conversion_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_conversions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: value %h count %0d",
                        rsp_value_bits, rsp_consumed_count);
         end else begin
            e = expected_conversions.pop_front();
            if (e.bits !== rsp_value_bits || e.count !== rsp_consumed_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("wrong result: expected value %h count %0d, got %h count %0d",
                           e.bits, e.count, rsp_value_bits, rsp_consumed_count);
            end
         end
      end
   end

   initial begin
      char_item_type it;
      int            k;
      add_text("-0", " ", 0, 0);
      add_text("+", 8'h00, 0, 0);
      add_text("-", "x", 0, 0);
      add_text(".", ",", 0, 0);
      add_text("e", " ", 0, 0);
      add_text("-E-", " ", 0, 0);
      add_text("1.5e-3", 8'hFF, 0, 0);
      add_text("12.75E+2", " ", 0, 0);
      add_text("1e400", " ", 0, 0);
      add_text("-1e-400", " ", 0, 0);
      add_text("9e99999", " ", 0, 0);
      add_text("0e99999", " ", 0, 0);
      add_text("99999999999999999999999", " ", 0, 1);
      // A terminator that fits continues the text, and a new beginning cuts a text short.
      add_text("7", "5", 0, 0);
      add_text("3.2", "8", 1, 0);
      add_text("45", " ", 0, 0);
      add_text("0.1", "e", 0, 0);
      add_text("12e", "Q", 0, 0);
      while (pending_chars.size() < 1600) begin
         k = $urandom_range(19);
         if (k == 0) begin
            it.ch = $urandom_range(255);
            it.begins = $urandom_range(1);
            it.drain = 0;
            pending_chars.push_back(it);
         end else begin
            add_text(random_number(),
                     $urandom_range(1) ? 8'h20 : 8'($urandom_range(255)),
                     $urandom_range(15) == 0, k == 1);
         end
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_chars.size() == 0 && expected_conversions.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_conversions.size() == 0)
         $display("decimal_text_to_double_top: match");
      else
         $display("decimal_text_to_double_top: mismatch");
      $finish;
   end

   initial begin
      #300_000_000;
      $display("decimal_text_to_double_top: mismatch");
      $finish;
   end

endmodule
